// File: rtl/core/xrr_pkg.sv
package xrr_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [DataW-1:0] GenReset = 32'h1176_0001;

  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  // Step count of the remainder unit: one quotient bit per cycle
  localparam int unsigned DivCntW = 5;
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DataW - 1);

  typedef enum logic [1:0] {
    CMD_RESEED = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_BOUND  = 2'd2,
    CMD_RANGE  = 2'd3
  } xrr_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } xrr_state_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } xrr_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } xrr_div_sts_t;

  // One xorshift32 step
  function automatic logic [DataW-1:0] xorshift_step(input logic [DataW-1:0] x);
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    a = x ^ (x << ShiftA);
    b = a ^ (a >> ShiftB);
    return b ^ (b << ShiftC);
  endfunction

endpackage

// File: rtl/core/xrr_if.sv
interface xrr_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [xrr_pkg::DataW-1:0] seed_value;
  logic [xrr_pkg::DataW-1:0] lower_bound;
  logic [xrr_pkg::DataW-1:0] upper_bound;

  modport source (output valid, cmd, seed_value, lower_bound, upper_bound, input ready);
  modport sink   (input valid, cmd, seed_value, lower_bound, upper_bound, output ready);
endinterface

interface xrr_out_if;
  logic                     valid;
  logic                     ready;
  logic [xrr_pkg::DataW-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

// File: rtl/core/xrr_rem_unit.sv
module xrr_rem_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  xrr_pkg::xrr_div_ctl_t        ctl_i,
  output xrr_pkg::xrr_div_sts_t        sts_o,
  output logic [xrr_pkg::DataW-1:0]    rem_o
);

  localparam int unsigned W = xrr_pkg::DataW;

  logic                        busy_q, busy_d;
  logic [xrr_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]                num_q, num_d;
  logic [W-1:0]                div_q, div_d;
  logic [W-1:0]                rem_q, rem_d;
  logic [W:0]                  shifted;
  logic [W+1:0]                diff;
  logic                        last;

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial remainder
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  // Shift in one dividend bit, subtract the divisor when it fits
  always_comb begin
    shifted = {rem_q, num_q[W-1]};
    diff    = {1'b0, shifted} - {2'b00, div_q};
    last    = busy_q && (cnt_q == '0);
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    div_d   = div_q;
    rem_d   = rem_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = xrr_pkg::DivLastStep;
      num_d  = ctl_i.dividend;
      div_d  = ctl_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[W-2:0], 1'b0};
      rem_d = diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = last;
  assign rem_o      = rem_q;

  // A start always launches a pass
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> busy_q)
    else $error("remainder unit did not start");

  // A finished remainder is below a nonzero divisor
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last && div_q != '0) |=> (rem_q < div_q))
    else $error("remainder not below divisor");

endmodule

// File: rtl/core/xorshift32_range_random_core.sv
// Channel  Dir  Fields                                      Handshake
// in_i     in   cmd, seed_value, lower_bound, upper_bound   valid/ready
// out_o    out  value                                       valid/ready
//
// Reseed gives no item. Raw draws and draws that skip the reduction (zero
// bound, empty range) pass from accept to loading the output register;
// bounded and range draws pass through accept, 32 shift-subtract steps of
// the shared remainder unit, then the low-bound add and output load.
// Reset (rst_ni low, asynchronous) loads the state 0x11760001 and empties
// the output register. A stalled output holds its item; the next item is
// accepted once the result has moved into the output register.
module xorshift32_range_random_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  xrr_in_if.sink       in_i,
  xrr_out_if.source    out_o
);

  localparam int unsigned W = xrr_pkg::DataW;

  xrr_pkg::xrr_state_e   state_q, state_d;
  logic [W-1:0]          gen_q, gen_d;
  logic [W-1:0]          base_q, base_d;
  logic                  use_rem_q, use_rem_d;
  logic                  out_valid_q, out_valid_d;
  logic [W-1:0]          out_value_q, out_value_d;
  logic [W-1:0]          gen_next;
  logic [W-1:0]          span;
  logic                  empty_range;
  logic                  accept;
  logic                  out_free;
  logic [W-1:0]          rem;
  xrr_pkg::xrr_div_ctl_t div_ctl;
  xrr_pkg::xrr_div_sts_t div_sts;

  xrr_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .sts_o  (div_sts),
    .rem_o  (rem)
  );

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xrr_pkg::ST_IDLE;
      gen_q       <= xrr_pkg::GenReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    use_rem_q   <= use_rem_d;
    out_value_q <= out_value_d;
  end

  assign gen_next    = xrr_pkg::xorshift_step(gen_q);
  assign empty_range = $signed(in_i.lower_bound) >= $signed(in_i.upper_bound);
  assign accept      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  // Sequence commands through the remainder unit
  always_comb begin
    state_d          = state_q;
    gen_d            = gen_q;
    base_d           = base_q;
    use_rem_d        = use_rem_q;
    out_valid_d      = out_valid_q;
    out_value_d      = out_value_q;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = gen_next >> 1;
    span             = in_i.upper_bound;
    in_i.ready       = 1'b0;

    // Drop the output item once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      xrr_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          unique case (in_i.cmd)
            xrr_pkg::CMD_RESEED: begin
              if (in_i.seed_value != '0) begin
                gen_d = in_i.seed_value;
              end
            end
            xrr_pkg::CMD_RAW: begin
              gen_d     = gen_next;
              base_d    = gen_next >> 1;
              use_rem_d = 1'b0;
              state_d   = xrr_pkg::ST_DONE;
            end
            xrr_pkg::CMD_BOUND: begin
              span      = in_i.upper_bound;
              base_d    = '0;
              use_rem_d = (span != '0);
              if (span != '0) begin
                gen_d         = gen_next;
                div_ctl.start = 1'b1;
                state_d       = xrr_pkg::ST_DIV;
              end else begin
                state_d = xrr_pkg::ST_DONE;
              end
            end
            xrr_pkg::CMD_RANGE: begin
              span      = in_i.upper_bound - in_i.lower_bound;
              base_d    = in_i.lower_bound;
              use_rem_d = !empty_range;
              if (!empty_range) begin
                gen_d         = gen_next;
                div_ctl.start = 1'b1;
                state_d       = xrr_pkg::ST_DIV;
              end else begin
                state_d = xrr_pkg::ST_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      xrr_pkg::ST_DIV: begin
        if (div_sts.done) begin
          state_d = xrr_pkg::ST_DONE;
        end
      end
      xrr_pkg::ST_DONE: begin
        // Load the output register when it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = base_q + (use_rem_q ? rem : '0);
          state_d     = xrr_pkg::ST_IDLE;
        end
      end
      default: state_d = xrr_pkg::ST_IDLE;
    endcase

    div_ctl.divisor = span;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_value_q;

  // The generator state never collapses to zero
  a_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != '0)
    else $error("generator state became zero");

  // A zero seed leaves the state unchanged
  a_zero_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.cmd == xrr_pkg::CMD_RESEED && in_i.seed_value == '0)
      |=> $stable(gen_q))
    else $error("zero seed changed state");

  // The remainder unit runs only while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.busy |-> (state_q == xrr_pkg::ST_DIV))
    else $error("remainder unit busy outside divide state");

endmodule

// File: dv/xorshift32_range_random_checker.sv
`timescale 1ns / 100ps

module xorshift32_range_random_checker
  import xrr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  xrr_in_if    in_mon,
  xrr_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  // Predicted generator state and the draws still to come out of the block
  logic [DataW-1:0] gen_state;
  logic [DataW-1:0] draw_q[$];

  // Advance the generator one xorshift step and answer the new state halved
  function automatic logic [DataW-1:0] advance_gen();
    logic [DataW-1:0] x;
    x = gen_state;
    x = x ^ {x[DataW-14:0], 13'b0};
    x = x ^ {17'b0, x[DataW-1:17]};
    x = x ^ {x[DataW-6:0], 5'b0};
    gen_state = x;
    return {1'b0, x[DataW-1:1]};
  endfunction

  // Draw below an unsigned bound; a zero bound leaves the generator alone
  function automatic logic [DataW-1:0] draw_below(input logic [DataW-1:0] bound);
    logic [DataW-1:0] raw;
    if (bound == '0) begin
      return '0;
    end
    raw = advance_gen();
    return raw % bound;
  endfunction

  // Apply one command to the predicted state; return 1 when it gives a draw
  function automatic bit predict_draw(input xrr_cmd_e cmd,
                                      input logic [DataW-1:0] seed,
                                      input logic [DataW-1:0] lo,
                                      input logic [DataW-1:0] hi,
                                      output logic [DataW-1:0] draw);
    draw = '0;
    case (cmd)
      CMD_RESEED: begin
        if (seed != '0) begin
          gen_state = seed;
        end
        return 1'b0;
      end
      CMD_RAW: draw = advance_gen();
      CMD_BOUND: draw = draw_below(hi);
      default: begin
        // empty signed range answers the low bound; the span wraps
        if ($signed(lo) >= $signed(hi)) begin
          draw = lo;
        end else begin
          draw = lo + draw_below(hi - lo);
        end
      end
    endcase
    return 1'b1;
  endfunction

  // Compare each result first, then predict from the accepted command
  always @(posedge clk_i or negedge rst_ni) begin : track_draws
    logic [DataW-1:0] want;
    logic [DataW-1:0] got;
    logic [DataW-1:0] draw;
    if (!rst_ni) begin
      gen_state = GenReset;
      draw_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.value;
        if (draw_q.size() == 0) begin
          $display("%0t: unexpected item, value %h", $time, got);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = draw_q.pop_front();
          if (got !== want) begin
            $display("%0t: value mismatch, expected %h, actual %h", $time, want, got);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (predict_draw(xrr_cmd_e'(in_mon.cmd), in_mon.seed_value,
                         in_mon.lower_bound, in_mon.upper_bound, draw)) begin
          draw_q.push_back(draw);
        end
      end
      pending_o = draw_q.size();
    end
  end

endmodule

// File: dv/xorshift32_range_random_core_tb.sv
`timescale 1ns / 100ps

module xorshift32_range_random_core_tb;
  import xrr_pkg::*;

  localparam int RandPerPhase  = 230;
  localparam int HoldCycles    = 200;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  int fail_count;
  int pending;
  int snd_idle_pct;
  int rcv_idle_pct;
  int quiet_cycles;
  bit hold_req;

  xrr_in_if  in_if ();
  xrr_out_if out_if ();

  xorshift32_range_random_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  xorshift32_range_random_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one command, with random gaps ahead of it; hold until accepted
  task automatic send_cmd(input xrr_cmd_e cmd, input logic [DataW-1:0] seed,
                          input logic [DataW-1:0] lo, input logic [DataW-1:0] hi);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.seed_value  <= seed;
    in_if.lower_bound <= lo;
    in_if.upper_bound <= hi;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every draw has come out
  task automatic drain_draws();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Word biased toward small, small negative and corner values
  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 4))
      0: return DataW'($urandom_range(0, 15));
      1: return DataW'(0) - DataW'($urandom_range(1, 16));
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'h7fff_ffff;
          3: return 32'h8000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // One random command with random content
  task automatic send_random();
    int sel;
    logic [DataW-1:0] seed;
    sel = $urandom_range(0, 9);
    seed = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
    if (sel == 0) begin
      send_cmd(CMD_RESEED, seed, pick_word(), pick_word());
    end else if (sel <= 3) begin
      send_cmd(CMD_RAW, seed, pick_word(), pick_word());
    end else if (sel <= 6) begin
      send_cmd(CMD_BOUND, seed, pick_word(), pick_word());
    end else begin
      send_cmd(CMD_RANGE, seed, pick_word(), pick_word());
    end
  endtask

  // Result side: random stalls plus one long hold on request
  initial begin : drive_ready
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d draws outstanding", $time, pending);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    quiet_cycles = 0;
    hold_req = 1'b0;
    snd_idle_pct = 21;
    rcv_idle_pct = 63;
    rst_ni = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.cmd         <= CMD_RESEED;
    in_if.seed_value  <= '0;
    in_if.lower_bound <= '0;
    in_if.upper_bound <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, zero seed, corner seeds, bounds and ranges
    send_cmd(CMD_RAW,    '0,           '0,           '0);
    send_cmd(CMD_RESEED, '0,           '0,           '0);
    send_cmd(CMD_RAW,    '0,           '0,           '0);
    send_cmd(CMD_RESEED, 32'h0000_0001, '0,          '0);
    send_cmd(CMD_RAW,    '0,           '0,           '0);
    send_cmd(CMD_RESEED, 32'hffff_ffff, '0,          '0);
    send_cmd(CMD_RAW,    32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(CMD_BOUND,  '0,           '0,           32'h0000_0000);
    send_cmd(CMD_BOUND,  '0,           '0,           32'h0000_0001);
    send_cmd(CMD_BOUND,  '0,           '0,           32'hffff_ffff);
    send_cmd(CMD_BOUND,  '0,           '0,           32'h8000_0000);
    send_cmd(CMD_BOUND,  '0,           '0,           32'h0000_0007);
    send_cmd(CMD_RANGE,  '0,           32'h0000_0005, 32'h0000_0005);
    send_cmd(CMD_RANGE,  '0,           32'h0000_0005, 32'hffff_fffd);
    send_cmd(CMD_RANGE,  '0,           32'h7fff_ffff, 32'h8000_0000);
    send_cmd(CMD_RANGE,  '0,           32'h8000_0000, 32'h7fff_ffff);
    send_cmd(CMD_RANGE,  '0,           32'hffff_fff6, 32'h0000_000a);
    send_cmd(CMD_RANGE,  '0,           32'h8000_0000, 32'h8000_0001);
    send_cmd(CMD_RANGE,  '0,           32'h0000_0000, 32'h7fff_ffff);
    send_cmd(CMD_RESEED, 32'h8000_0000, '0,          '0);
    send_cmd(CMD_RAW,    '0,           '0,           '0);

    // Random: three idling mixes, a long result hold and a full drain
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 21;
          rcv_idle_pct = 63;
        end
        1: begin
          snd_idle_pct = 63;
          rcv_idle_pct = 21;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        if (ph == 0 && n == 40) begin
          hold_req = 1'b1;
        end
        if (ph == 2 && n == 100) begin
          drain_draws();
        end
        send_random();
      end
    end

    // Wait out the remaining draws, then watch for strays
    drain_draws();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
